### rtl/core/cpa_pkg.sv
// Shared types and constants for the contiguous page allocator.
// Used by every module under rtl/core but cpa_ram; depends on nothing.
package cpa_pkg;

   localparam int TABLE_DEPTH = 4096;
   localparam int PAGE_SHIFT  = 12;
   localparam int PAGE_BITS   = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = PAGE_BITS + 1;
   localparam int ADDR_W      = 32;
   localparam int COUNT_W     = 13;
   localparam int PGN_W       = ADDR_W - PAGE_SHIFT;
   localparam int RANGE_W     = PGN_W + 2;

   typedef enum logic [1:0] {
      OP_ALLOC  = 2'd0,
      OP_FREE   = 2'd1,
      OP_MARK   = 2'd2,
      OP_UNUSED = 2'd3
   } opcode_type;

   localparam logic [1:0] PS_HARDWARE  = 2'd0;
   localparam logic [1:0] PS_NO_MEM    = 2'd1;
   localparam logic [1:0] PS_ALLOCATED = 2'd2;
   localparam logic [1:0] PS_FREE      = 2'd3;

   typedef enum logic [2:0] {
      ST_OK            = 3'd0,
      ST_MISALIGNED    = 3'd1,
      ST_NO_ROOM       = 3'd2,
      ST_NOT_ALLOCATED = 3'd3,
      ST_OUT_OF_RANGE  = 3'd4,
      ST_ZERO_COUNT    = 3'd5
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       clr_write;
      logic       load;
      logic       init_scan;
      logic       scan;
      logic       mark_write;
      logic       wr_step;
      logic       res_we;
      status_type res_code;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      opcode_type op;
      status_type pre_code;
      logic       at_end;
      logic       scan_hit;
      logic       scan_fail;
      status_type fail_code;
   } sts_type;

endpackage

### rtl/core/contiguous_page_allocator_top.sv
// Top level of the first-fit contiguous page allocator.
// Depends on cpa_pkg, cpa_ctrl and cpa_datapath (which holds cpa_ram).
//
//   Channel   Ports                                   Handshake
//   request   req_opcode, req_page_address,           taken when start && !busy
//             req_page_count, req_new_state
//   response  rsp_ok, rsp_status, rsp_base_address    one cycle with rsp_valid
//
// Mark and any request refused by the up-front checks are answered from the check
// state. Allocate scans the page table one entry per cycle through the RAM read
// port, from page 1 up to the end of the first fitting run, then writes the run one
// page per cycle. Free reads its run and then writes it, and stops at the first
// page that is not allocated. After reset the table is cleared one entry per cycle
// with busy high. The receiver cannot stall; each response word is held for
// exactly one cycle.
module contiguous_page_allocator_top
   import cpa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic [ADDR_W-1:0]  req_page_address,
   input  logic [COUNT_W-1:0] req_page_count,
   input  logic [1:0]         req_new_state,
   output logic               rsp_valid,
   output logic               rsp_ok,
   output logic [2:0]         rsp_status,
   output logic [ADDR_W-1:0]  rsp_base_address
);

   cmd_type cmd;
   sts_type sts;

   cpa_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .rsp_valid(rsp_valid),
      .cmd      (cmd),
      .sts      (sts)
   );

   cpa_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_opcode      (req_opcode),
      .req_page_address(req_page_address),
      .req_page_count  (req_page_count),
      .req_new_state   (req_new_state),
      .rsp_ok          (rsp_ok),
      .rsp_status      (rsp_status),
      .rsp_base_address(rsp_base_address)
   );

endmodule

### rtl/core/cpa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
module cpa_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/cpa_datapath.sv
// Datapath: request capture, checks, page pointer, run counter, result
// registers and the page state table. Depends on cpa_pkg and cpa_ram.
module cpa_datapath
   import cpa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  logic [1:0]         req_opcode,
   input  logic [ADDR_W-1:0]  req_page_address,
   input  logic [COUNT_W-1:0] req_page_count,
   input  logic [1:0]         req_new_state,
   output logic               rsp_ok,
   output logic [2:0]         rsp_status,
   output logic [ADDR_W-1:0]  rsp_base_address
);

   opcode_type          op_ff, op_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [1:0]          nstate_ff, nstate_in;
   logic [CNT_W-1:0]    ptr_ff, ptr_in;
   logic [PAGE_BITS-1:0] end_ff, end_in;
   logic [PAGE_BITS-1:0] first_ff, first_in;
   logic [COUNT_W-1:0]  run_ff, run_in;
   logic                rd_vld_ff, rd_vld_in;
   logic [PAGE_BITS-1:0] rd_page_ff, rd_page_in;
   status_type          res_status_ff, res_status_in;
   logic [ADDR_W-1:0]   res_base_ff, res_base_in;

   logic [PGN_W-1:0]     pgn;
   logic [RANGE_W-1:0]   pgn_x;
   logic [RANGE_W-1:0]   end_x;
   logic                 aligned;
   logic                 zero_count;
   logic                 out_range;
   logic [PAGE_BITS-1:0] page_lo;
   logic [PAGE_BITS-1:0] last_pg;
   status_type           pre_code;
   logic                 issue_en;
   logic                 rd_en;
   logic [1:0]           rd_data;
   logic                 wr_en;
   logic [PAGE_BITS-1:0] wr_addr;
   logic [1:0]           wr_data;
   logic [COUNT_W-1:0]   run_inc;
   logic                 is_free;
   logic                 hit;
   logic                 fail;
   status_type           fail_code;
   logic [ADDR_W-1:0]    hit_first_w;

   cpa_ram #(
      .WIDTH(2),
      .DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(page_lo),
      .rd_data(rd_data)
   );

   // Request checks, evaluated on the captured request.
   assign pgn        = addr_ff[ADDR_W-1:PAGE_SHIFT];
   assign pgn_x      = RANGE_W'(pgn);
   assign end_x      = pgn_x + RANGE_W'(count_ff);
   assign aligned    = (addr_ff[PAGE_SHIFT-1:0] == '0);
   assign zero_count = (count_ff == '0);
   assign out_range  = (pgn_x >= RANGE_W'(TABLE_DEPTH));
   assign last_pg    = PAGE_BITS'(end_x - RANGE_W'(1));
   assign page_lo    = ptr_ff[PAGE_BITS-1:0];

   always_comb begin
      pre_code = ST_OK;
      case (op_ff)
         OP_ALLOC: begin
            if (zero_count) pre_code = ST_ZERO_COUNT;
         end
         OP_FREE: begin
            if (!aligned) pre_code = ST_MISALIGNED;
            else if (zero_count) pre_code = ST_ZERO_COUNT;
            else if (out_range || end_x > RANGE_W'(TABLE_DEPTH)) pre_code = ST_OUT_OF_RANGE;
         end
         OP_MARK: begin
            if (!aligned) pre_code = ST_MISALIGNED;
            else if (out_range) pre_code = ST_OUT_OF_RANGE;
         end
         default: pre_code = ST_OUT_OF_RANGE;
      endcase
   end

   // Scan: a read issued in one cycle is evaluated in the next.
   assign issue_en    = (ptr_ff <= CNT_W'(end_ff));
   assign rd_en       = cmd.scan && issue_en;
   assign run_inc     = run_ff + COUNT_W'(1);
   assign is_free     = (rd_data == PS_FREE);
   assign hit_first_w = ADDR_W'(rd_page_ff) + ADDR_W'(1) - ADDR_W'(count_ff);

   always_comb begin
      hit       = 1'b0;
      fail      = 1'b0;
      fail_code = ST_NO_ROOM;
      if (rd_vld_ff) begin
         if (op_ff == OP_ALLOC) begin
            hit       = is_free && (run_inc == count_ff);
            fail      = !hit && (rd_page_ff == end_ff);
            fail_code = ST_NO_ROOM;
         end else begin
            fail      = (rd_data != PS_ALLOCATED);
            hit       = !fail && (rd_page_ff == end_ff);
            fail_code = ST_NOT_ALLOCATED;
         end
      end
   end

   // Table write port: clearing pass, mark, or the run write pass.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = page_lo;
      wr_data = PS_NO_MEM;
      if (cmd.clr_write) begin
         wr_en = 1'b1;
      end else if (cmd.mark_write) begin
         wr_en   = 1'b1;
         wr_addr = pgn[PAGE_BITS-1:0];
         wr_data = nstate_ff;
      end else if (cmd.wr_step) begin
         wr_en   = 1'b1;
         wr_data = (op_ff == OP_ALLOC) ? PS_ALLOCATED : PS_FREE;
      end
   end

   always_comb begin
      op_in         = op_ff;
      addr_in       = addr_ff;
      count_in      = count_ff;
      nstate_in     = nstate_ff;
      ptr_in        = ptr_ff;
      end_in        = end_ff;
      first_in      = first_ff;
      run_in        = run_ff;
      rd_vld_in     = rd_en;
      rd_page_in    = page_lo;
      res_status_in = res_status_ff;
      res_base_in   = res_base_ff;
      if (cmd.load) begin
         op_in     = opcode_type'(req_opcode);
         addr_in   = req_page_address;
         count_in  = req_page_count;
         nstate_in = req_new_state;
      end
      if (cmd.clr_write || cmd.wr_step) begin
         ptr_in = ptr_ff + CNT_W'(1);
      end
      if (cmd.init_scan) begin
         run_in = '0;
         if (op_ff == OP_ALLOC) begin
            ptr_in = CNT_W'(1);
            end_in = PAGE_BITS'(TABLE_DEPTH - 1);
         end else begin
            ptr_in = CNT_W'(pgn[PAGE_BITS-1:0]);
            end_in = last_pg;
         end
      end
      if (cmd.scan) begin
         if (rd_en) begin
            ptr_in = ptr_ff + CNT_W'(1);
         end
         if (rd_vld_ff && op_ff == OP_ALLOC) begin
            run_in = is_free ? run_inc : '0;
         end
         if (hit) begin
            if (op_ff == OP_ALLOC) begin
               first_in = PAGE_BITS'(hit_first_w);
               ptr_in   = CNT_W'(PAGE_BITS'(hit_first_w));
               end_in   = rd_page_ff;
            end else begin
               ptr_in = CNT_W'(pgn[PAGE_BITS-1:0]);
            end
         end
      end
      if (cmd.res_we) begin
         res_status_in = cmd.res_code;
         res_base_in   = (op_ff == OP_ALLOC && cmd.res_code == ST_OK)
                         ? (ADDR_W'(first_ff) << PAGE_SHIFT) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff    <= '0;
         end_ff    <= PAGE_BITS'(TABLE_DEPTH - 1);
         rd_vld_ff <= 1'b0;
         op_ff     <= OP_ALLOC;
      end else begin
         ptr_ff    <= ptr_in;
         end_ff    <= end_in;
         rd_vld_ff <= rd_vld_in;
         op_ff     <= op_in;
      end
      addr_ff       <= addr_in;
      count_ff      <= count_in;
      nstate_ff     <= nstate_in;
      first_ff      <= first_in;
      run_ff        <= run_in;
      rd_page_ff    <= rd_page_in;
      res_status_ff <= res_status_in;
      res_base_ff   <= res_base_in;
   end

   assign sts.op        = op_ff;
   assign sts.pre_code  = pre_code;
   assign sts.at_end    = (page_lo == end_ff);
   assign sts.scan_hit  = hit;
   assign sts.scan_fail = fail;
   assign sts.fail_code = fail_code;

   assign rsp_ok           = (res_status_ff == ST_OK);
   assign rsp_status       = res_status_ff;
   assign rsp_base_address = res_base_ff;

endmodule

### rtl/core/cpa_ctrl.sv
// Controller state machine: clearing pass, request checks, scan and write
// pass sequencing, busy and result strobe. Depends on cpa_pkg.
module cpa_ctrl
   import cpa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   output logic    rsp_valid,
   output cmd_type cmd,
   input  sts_type sts
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_CHECK,
      S_SCAN,
      S_WRITE
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      cmd.res_code = ST_OK;
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_write = 1'b1;
            if (sts.at_end) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.pre_code != ST_OK) begin
               cmd.res_we   = 1'b1;
               cmd.res_code = sts.pre_code;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else if (sts.op == OP_MARK) begin
               cmd.mark_write = 1'b1;
               cmd.res_we     = 1'b1;
               rsp_valid_in   = 1'b1;
               state_in       = S_IDLE;
            end else begin
               cmd.init_scan = 1'b1;
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_fail) begin
               cmd.res_we   = 1'b1;
               cmd.res_code = sts.fail_code;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else if (sts.scan_hit) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            cmd.wr_step = 1'b1;
            if (sts.at_end) begin
               cmd.res_we   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      busy_in = (state_in != S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         busy_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for contiguous_page_allocator_top: a queue-fed driver,
// a response monitor and a page map predictor that tracks every page state.
// Depends on cpa_pkg and the allocator RTL.
module testbench;
   import cpa_pkg::*;

   localparam int MAX_WORDS   = 240;
   localparam int WORD_CYCLES = 2 * TABLE_DEPTH + 40;
   localparam int CYCLE_LIMIT = 4 * (TABLE_DEPTH + MAX_WORDS * WORD_CYCLES);

   typedef struct {
      opcode_type         op;
      logic [ADDR_W-1:0]  addr;
      logic [COUNT_W-1:0] count;
      logic [1:0]         new_state;
   } page_request;

   typedef struct {
      logic              ok;
      status_type        status;
      logic [ADDR_W-1:0] base;
   } page_reply;

   typedef struct {
      int first_page;
      int pages;
   } page_run;

   logic               clock;
   logic               reset;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_opcode = '0;
   logic [ADDR_W-1:0]  req_page_address = '0;
   logic [COUNT_W-1:0] req_page_count = '0;
   logic [1:0]         req_new_state = '0;
   logic               rsp_valid;
   logic               rsp_ok;
   logic [2:0]         rsp_status;
   logic [ADDR_W-1:0]  rsp_base_address;

   page_request pending_words[$];
   page_reply   expected_replies[$];
   page_run     granted_runs[$];
   logic [1:0]  page_map [TABLE_DEPTH];

   int words_queued = 0;
   int words_sent = 0;
   int words_taken = 0;
   int idle_left = 0;
   bit quiet = 1'b0;
   int mismatches = 0;
   int replies_checked = 0;
   int cycles = 0;
   int op_seen [4] = '{0, 0, 0, 0};
   int grants = 0;
   int frees_done = 0;

   contiguous_page_allocator_top u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_page_address (req_page_address),
      .req_page_count   (req_page_count),
      .req_new_state    (req_new_state),
      .rsp_valid        (rsp_valid),
      .rsp_ok           (rsp_ok),
      .rsp_status       (rsp_status),
      .rsp_base_address (rsp_base_address)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Applies one request to the page map and returns the reply it must produce.
   function automatic page_reply apply_to_page_map(page_request rq);
      page_reply rp;
      int        pages;
      int        run_len;
      int        first;
      int        p;
      bit        found;
      rp.status = ST_OK;
      rp.base   = '0;
      pages     = int'(rq.count);
      first     = 0;
      case (rq.op)
         OP_ALLOC: begin
            if (pages == 0) begin
               rp.status = ST_ZERO_COUNT;
            end else begin
               run_len = 0;
               found   = 1'b0;
               for (p = 1; p < TABLE_DEPTH; p++) begin
                  if (page_map[p] == PS_FREE) begin
                     run_len++;
                     if (run_len == pages) begin
                        first = p + 1 - pages;
                        found = 1'b1;
                        break;
                     end
                  end else begin
                     run_len = 0;
                  end
               end
               if (found) begin
                  for (p = first; p < first + pages; p++) page_map[p] = PS_ALLOCATED;
                  rp.base = ADDR_W'(first) << PAGE_SHIFT;
               end else begin
                  rp.status = ST_NO_ROOM;
               end
            end
         end
         OP_FREE: begin
            first = int'(rq.addr >> PAGE_SHIFT);
            if (rq.addr[PAGE_SHIFT-1:0] != '0) begin
               rp.status = ST_MISALIGNED;
            end else if (pages == 0) begin
               rp.status = ST_ZERO_COUNT;
            end else if (first >= TABLE_DEPTH || first + pages > TABLE_DEPTH) begin
               rp.status = ST_OUT_OF_RANGE;
            end else begin
               for (p = first; p < first + pages; p++)
                  if (page_map[p] != PS_ALLOCATED) rp.status = ST_NOT_ALLOCATED;
               if (rp.status == ST_OK)
                  for (p = first; p < first + pages; p++) page_map[p] = PS_FREE;
            end
         end
         OP_MARK: begin
            first = int'(rq.addr >> PAGE_SHIFT);
            if (rq.addr[PAGE_SHIFT-1:0] != '0) begin
               rp.status = ST_MISALIGNED;
            end else if (first >= TABLE_DEPTH) begin
               rp.status = ST_OUT_OF_RANGE;
            end else begin
               page_map[first] = rq.new_state;
            end
         end
         default: rp.status = ST_OUT_OF_RANGE;
      endcase
      rp.ok = (rp.status == ST_OK);
      if (!rp.ok) rp.base = '0;
      return rp;
   endfunction

   function automatic logic [ADDR_W-1:0] page_addr(int page);
      return ADDR_W'(page) << PAGE_SHIFT;
   endfunction

   task automatic queue_word(opcode_type op, logic [ADDR_W-1:0] addr, int count,
                             logic [1:0] new_state);
      page_request rq;
      rq.op        = op;
      rq.addr      = addr;
      rq.count     = COUNT_W'(count);
      rq.new_state = new_state;
      pending_words.push_back(rq);
      words_queued++;
   endtask

   // Driver: holds a word until the block takes it, with random idle bursts
   // between words.
   always @(negedge clock) begin
      page_request rq;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || words_taken == words_sent) begin
         if (start && !quiet && $urandom_range(0, 3) == 0)
            idle_left = $urandom_range(1, 14);
         if (idle_left > 0) begin
            idle_left--;
            start            <= 1'b0;
            req_opcode       <= 2'($urandom_range(0, 3));
            req_page_address <= $urandom();
            req_page_count   <= COUNT_W'($urandom());
            req_new_state    <= 2'($urandom_range(0, 3));
         end else if (pending_words.size() > 0) begin
            rq = pending_words.pop_front();
            start            <= 1'b1;
            req_opcode       <= rq.op;
            req_page_address <= rq.addr;
            req_page_count   <= rq.count;
            req_new_state    <= rq.new_state;
            words_sent++;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: checks each response word, then predicts for a word taken at this edge.
   always @(posedge clock) begin
      page_reply   exp_rp;
      page_request rq;
      page_run     run;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected response word: ok %0b status %0d base 0x%08h",
                        rsp_ok, rsp_status, rsp_base_address);
         end else begin
            exp_rp = expected_replies.pop_front();
            replies_checked++;
            if (rsp_ok !== exp_rp.ok || rsp_status !== exp_rp.status ||
                rsp_base_address !== exp_rp.base) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $write("Mismatch on response %0d: expected ok %0b status %0d base 0x%08h,",
                         replies_checked, exp_rp.ok, exp_rp.status, exp_rp.base);
                  $display(" got ok %0b status %0d base 0x%08h",
                           rsp_ok, rsp_status, rsp_base_address);
               end
            end
         end
      end
      if (!reset && start && busy === 1'b0) begin
         rq.op        = opcode_type'(req_opcode);
         rq.addr      = req_page_address;
         rq.count     = req_page_count;
         rq.new_state = req_new_state;
         exp_rp = apply_to_page_map(rq);
         expected_replies.push_back(exp_rp);
         op_seen[req_opcode]++;
         if (rq.op == OP_ALLOC && exp_rp.ok) begin
            run.first_page = int'(exp_rp.base >> PAGE_SHIFT);
            run.pages      = int'(rq.count);
            granted_runs.push_back(run);
            grants++;
         end
         if (rq.op == OP_FREE && exp_rp.ok) frees_done++;
         words_taken++;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d responses outstanding.",
                  cycles, expected_replies.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int      n_random;
      int      kind;
      int      k;
      int      page;
      int      idx;
      page_run run;
      reset = 1'b1;
      for (int p = 0; p < TABLE_DEPTH; p++) page_map[p] = PS_NO_MEM;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed words: empty map, each error, page 0 and the top page, all states.
      queue_word(OP_ALLOC, '0, 1, PS_HARDWARE);
      queue_word(OP_ALLOC, '0, 0, PS_HARDWARE);
      queue_word(OP_MARK, 32'h0000_0801, 0, PS_FREE);
      queue_word(OP_MARK, page_addr(TABLE_DEPTH), 0, PS_FREE);
      queue_word(OP_MARK, 32'hFFFF_F000, 8191, PS_FREE);
      queue_word(OP_MARK, page_addr(0), 0, PS_FREE);
      for (int p = 1; p <= 8; p++)
         queue_word(OP_MARK, page_addr(p), 0, (p == 5) ? PS_HARDWARE : PS_FREE);
      queue_word(OP_MARK, page_addr(TABLE_DEPTH - 1), 4096, PS_FREE);
      queue_word(OP_ALLOC, 32'hFFFF_FFFF, 4, PS_FREE);
      queue_word(OP_ALLOC, '0, 4, PS_FREE);
      queue_word(OP_ALLOC, '0, 3, PS_FREE);
      queue_word(OP_ALLOC, '0, 1, PS_FREE);
      queue_word(OP_FREE, page_addr(1), 4, PS_HARDWARE);
      queue_word(OP_FREE, page_addr(1), 4, PS_HARDWARE);
      queue_word(OP_FREE, 32'h0000_1004, 1, PS_HARDWARE);
      queue_word(OP_FREE, page_addr(1), 0, PS_HARDWARE);
      queue_word(OP_FREE, page_addr(TABLE_DEPTH - 1), 2, PS_HARDWARE);
      queue_word(OP_FREE, page_addr(TABLE_DEPTH), 1, PS_HARDWARE);
      queue_word(OP_FREE, 32'hFFFF_F000, 8191, PS_HARDWARE);
      queue_word(OP_ALLOC, '0, 8191, PS_HARDWARE);
      queue_word(OP_ALLOC, '0, 4096, PS_HARDWARE);
      queue_word(OP_UNUSED, 32'hFFFF_FFFF, 8191, 2'b11);
      queue_word(OP_MARK, page_addr(5), 0, PS_ALLOCATED);
      queue_word(OP_MARK, page_addr(5), 0, PS_NO_MEM);

      // Random words: mostly map a few pages free and allocate from them,
      // or free runs that were granted; the rest is noise.
      n_random = 0;
      while (n_random < 110) begin
         quiet = (n_random >= 90);
         kind  = $urandom_range(0, 99);
         if (kind < 35) begin
            k    = $urandom_range(1, 4);
            page = $urandom_range(1, 60);
            for (int p = 0; p < k; p++) begin
               queue_word(OP_MARK, page_addr(page + p), $urandom_range(0, 8191),
                          ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 2)) : PS_FREE);
               n_random++;
            end
            queue_word(OP_ALLOC, $urandom(), $urandom_range(1, k + 1), 2'($urandom_range(0, 3)));
            n_random++;
         end else if (kind < 60) begin
            // The run list is filled at acceptance, so let the queue drain first.
            wait (words_taken == words_queued);
            if (granted_runs.size() > 0) begin
               idx = $urandom_range(0, granted_runs.size() - 1);
               run = granted_runs[idx];
               granted_runs.delete(idx);
               k = $urandom_range(0, 9);
               if (k == 0) run.pages++;
               else if (k == 1) run.first_page--;
               queue_word(OP_FREE, page_addr(run.first_page), run.pages,
                          2'($urandom_range(0, 3)));
            end else begin
               queue_word(OP_FREE, page_addr($urandom_range(0, 63)), $urandom_range(1, 4),
                          2'($urandom_range(0, 3)));
            end
            n_random++;
         end else if (kind < 70) begin
            queue_word(OP_ALLOC, $urandom(),
                       ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191)
                                                   : $urandom_range(0, 3),
                       2'($urandom_range(0, 3)));
            n_random++;
         end else if (kind < 80) begin
            page = ($urandom_range(0, 3) == 0)
                   ? $urandom_range(TABLE_DEPTH - 4, TABLE_DEPTH + 2)
                   : $urandom_range(0, 63);
            queue_word(OP_MARK, page_addr(page), $urandom_range(0, 8191),
                       2'($urandom_range(0, 3)));
            n_random++;
         end else begin
            queue_word(opcode_type'($urandom_range(0, 3)),
                       ($urandom_range(0, 1) == 0) ? $urandom()
                                                   : page_addr($urandom_range(0, 63)),
                       ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                                   : $urandom_range(0, 5),
                       2'($urandom_range(0, 3)));
            n_random++;
         end
      end

      wait (words_taken == words_queued);
      wait (expected_replies.size() == 0);
      repeat (40) @(posedge clock);
      if (expected_replies.size() > 0) begin
         mismatches += expected_replies.size();
         $display("%0d expected responses never arrived.", expected_replies.size());
      end
      $display("Sent %0d words: %0d allocate (%0d granted), %0d free (%0d done),",
               words_taken, op_seen[OP_ALLOC], grants, op_seen[OP_FREE], frees_done);
      $display("%0d mark and %0d unused opcode; checked %0d responses in %0d cycles.",
               op_seen[OP_MARK], op_seen[OP_UNUSED], replies_checked, cycles);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
